// ===== hdl/matrix3x3_arithmetic_unit_macros.svh =====
`ifndef MATRIX3X3_ARITHMETIC_UNIT_MACROS_SVH
`define MATRIX3X3_ARITHMETIC_UNIT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define M3AU_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("m3au: same-cycle check failed");

// Next-cycle implication, held off while reset is asserted.
`define M3AU_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("m3au: next-cycle check failed");

`endif

// ===== hdl/m3au_pkg.sv =====
`default_nettype none

package m3au_pkg;

    // Matrix geometry
    localparam int DIM    = 3;
    localparam int CELLS  = 9;
    localparam int IDX_W  = 2;
    localparam int ADDR_W = 4;
    localparam logic [IDX_W-1:0] LAST_IDX = 2'd2;

    // Result field
    localparam int RES_W = 25;
    localparam logic signed [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
    localparam logic signed [RES_W-1:0] RES_MIN = {1'b1, {(RES_W-1){1'b0}}};

    // Operation codes
    typedef enum logic [2:0] {
        OP_LOAD  = 3'd0,
        OP_MUL   = 3'd1,
        OP_ADD   = 3'd2,
        OP_SUB   = 3'd3,
        OP_SCALE = 3'd4,
        OP_DET   = 3'd5,
        OP_TRANS = 3'd6
    } op_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DETB
    } state_t;

    // Control that travels alongside a memory read
    typedef struct packed {
        op_t              op;
        logic             src;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [IDX_W-1:0] kk;
        logic             acc_clr;
        logic             emit;
        logic             last;
        logic             det_fin;
    } seq_tag_t;

    // Row-order address of a matrix element
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] row,
                                                     input logic [IDX_W-1:0] col);
        cell_addr = ADDR_W'({row, 1'b0}) + ADDR_W'(row) + ADDR_W'(col);
    endfunction

endpackage

`default_nettype wire

// ===== hdl/m3au_ram.sv =====
`default_nettype none

module m3au_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 9
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/matrix3x3_arithmetic_unit.sv =====
// 3x3 matrix arithmetic unit, holding matrices A and B in two small RAMs.
// Input channel s_*: one transaction per operation. A load writes one element
// into the selected RAM; loads may be accepted back to back. A compute
// transaction (multiply, add, subtract, scale, determinant, transpose) starts
// a run of results on the m_* channel; m_last marks the final one.
// s_ready is high only while no run is in progress.
// Each RAM has one read port, so a run issues one element read per matrix per
// cycle unless the output stalls: add/subtract issue 9 reads, scale/transpose
// 18, multiply 27 (three reads per element), determinant 18 plus a final step
// for the second result. Each read passes the RAM read register and stage 1
// into the output register; the block is ready again once the last read has
// drained, or for determinant once the second result enters the output register.
// Reset clears the element valid flags, so both matrices read as zero; no
// clearing pass is needed. When m_ready is held low with a result waiting, the
// read sequence stalls and nothing is dropped.
`default_nettype none

module matrix3x3_arithmetic_unit
    import m3au_pkg::*;
#(
    parameter int ELEMENT_WIDTH = 8
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic [2:0]              s_op,
    input  wire logic                    s_matrix_sel,
    input  wire logic [1:0]              s_row_index,
    input  wire logic [1:0]              s_col_index,
    input  wire logic signed [7:0]       s_element_value,
    input  wire logic [3:0]              s_scale_factor,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic signed [RES_W-1:0]      m_result_value,
    output logic                         m_result_kind,
    output logic                         m_source_matrix,
    output logic [1:0]                   m_out_row,
    output logic [1:0]                   m_out_col,
    output logic                         m_last
);

    localparam int EW      = ELEMENT_WIDTH;
    localparam int PROD2_W = 2 * EW;
    localparam int PROD3_W = 3 * EW;
    localparam int ACC_W   = 3 * EW + 3;
    localparam int EXT_W   = ACC_W + RES_W;
    localparam int SCL_W   = EW + 5;

    // Clamp a wide result into the output range
    function automatic logic [RES_W-1:0] sat_res(input logic signed [ACC_W-1:0] v);
        logic signed [EXT_W-1:0] vx;
        vx = EXT_W'(v);
        if (vx > EXT_W'(RES_MAX)) begin
            sat_res = RES_MAX;
        end else if (vx < EXT_W'(RES_MIN)) begin
            sat_res = RES_MIN;
        end else begin
            sat_res = RES_W'(vx);
        end
    endfunction

    state_t state_reg, state_next;

    op_t              op_reg;
    logic [3:0]       factor_reg;
    logic             s_reg, s_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [IDX_W-1:0] k_reg, k_next;

    logic [CELLS-1:0] valid_a_reg, valid_b_reg;

    seq_tag_t         st1_reg, tag_next;
    logic             st1_vld_reg;
    logic             rvld_a_reg, rvld_b_reg;

    logic signed [ACC_W-1:0]   acc_a_reg, acc_a_next, acc_b_reg, acc_b_next;
    logic signed [PROD2_W-1:0] prod_a_reg, prod_a_next, prod_b_reg, prod_b_next;

    logic                    out_vld_reg;
    logic signed [RES_W-1:0] out_value_reg;
    logic                    out_kind_reg, out_src_reg, out_last_reg;
    logic [IDX_W-1:0]        out_row_reg, out_col_reg;

    op_t               in_op;
    logic              accept, start, load_hit, is_compute;
    logic [ADDR_W-1:0] load_addr;
    logic              out_blocked, advance, issue, consume, final_step, detb_emit;
    logic [IDX_W-1:0]  kmax, jmax;
    logic              smax;
    logic [2:0]        diag;
    logic [IDX_W-1:0]  dmod, det_col;
    logic [ADDR_W-1:0] addr_a, addr_b;
    logic [EW-1:0]     rd_a, rd_b;

    logic signed [EW-1:0]      ea, eb, e_sel;
    logic signed [4:0]         fac_s;
    logic signed [SCL_W-1:0]   scale_prod;
    logic signed [PROD2_W-1:0] mul_x;
    logic signed [PROD3_W-1:0] mult_a, mult_b;
    logic signed [ACC_W-1:0]   term_a, term_b, base_a, base_b, rv;

    // Input decode
    assign in_op     = op_t'(s_op);
    assign accept    = s_valid && s_ready;
    assign load_addr = cell_addr(s_row_index, s_col_index);
    assign load_hit  = accept && (in_op == OP_LOAD) &&
                       (s_row_index <= LAST_IDX) && (s_col_index <= LAST_IDX);

    always_comb begin
        unique case (in_op)
            OP_MUL, OP_ADD, OP_SUB, OP_SCALE, OP_DET, OP_TRANS: is_compute = 1'b1;
            default:                                            is_compute = 1'b0;
        endcase
    end
    assign start = accept && is_compute;

    // Loop bounds per operation
    always_comb begin
        kmax = '0;
        jmax = LAST_IDX;
        smax = 1'b0;
        unique case (op_reg)
            OP_MUL: begin
                kmax = LAST_IDX;
            end
            OP_SCALE, OP_TRANS: begin
                smax = 1'b1;
            end
            OP_DET: begin
                kmax = LAST_IDX;
                jmax = '0;
                smax = 1'b1;
            end
            default: begin
                kmax = '0;
            end
        endcase
    end
    assign final_step = (k_reg == kmax) && (j_reg == jmax) &&
                        (i_reg == LAST_IDX) && (s_reg == smax);

    // Stall: stage 1 holds while its result cannot enter the output register
    assign out_blocked = out_vld_reg && !m_ready;
    assign advance     = !(st1_vld_reg && st1_reg.emit && out_blocked);
    assign consume     = st1_vld_reg && advance;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (advance && final_step) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (consume) begin
                    state_next = st1_reg.det_fin ? ST_DETB : ST_IDLE;
                end
            end
            ST_DETB: begin
                if (!out_blocked) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb begin
        s_ready   = 1'b0;
        issue     = 1'b0;
        detb_emit = 1'b0;
        unique case (state_reg)
            ST_IDLE:  s_ready   = 1'b1;
            ST_RUN:   issue     = advance;
            ST_DRAIN: issue     = 1'b0;
            ST_DETB:  detb_emit = !out_blocked;
            default:  s_ready   = 1'b0;
        endcase
    end

    // Nested step counters: k innermost, then j, i, s
    always_comb begin
        s_next = s_reg;
        i_next = i_reg;
        j_next = j_reg;
        k_next = k_reg;
        if (start) begin
            s_next = 1'b0;
            i_next = '0;
            j_next = '0;
            k_next = '0;
        end else if (issue) begin
            if (k_reg != kmax) begin
                k_next = k_reg + 1'b1;
            end else begin
                k_next = '0;
                if (j_reg != jmax) begin
                    j_next = j_reg + 1'b1;
                end else begin
                    j_next = '0;
                    if (i_reg != LAST_IDX) begin
                        i_next = i_reg + 1'b1;
                    end else begin
                        i_next = '0;
                        s_next = ~s_reg;
                    end
                end
            end
        end
    end

    // Read addresses; determinant walks the Sarrus diagonals row by row
    assign diag    = {1'b0, i_reg} + {1'b0, k_reg};
    assign dmod    = (diag >= 3'(DIM)) ? IDX_W'(diag - 3'(DIM)) : IDX_W'(diag);
    assign det_col = s_reg ? (LAST_IDX - dmod) : dmod;

    always_comb begin
        unique case (op_reg)
            OP_MUL: begin
                addr_a = cell_addr(i_reg, k_reg);
                addr_b = cell_addr(k_reg, j_reg);
            end
            OP_TRANS: begin
                addr_a = cell_addr(j_reg, i_reg);
                addr_b = cell_addr(j_reg, i_reg);
            end
            OP_DET: begin
                addr_a = cell_addr(k_reg, det_col);
                addr_b = cell_addr(k_reg, det_col);
            end
            default: begin
                addr_a = cell_addr(i_reg, j_reg);
                addr_b = cell_addr(i_reg, j_reg);
            end
        endcase
    end

    // Control tag for the read being issued
    always_comb begin
        tag_next.op      = op_reg;
        tag_next.src     = s_reg;
        tag_next.row     = i_reg;
        tag_next.col     = j_reg;
        tag_next.kk      = k_reg;
        tag_next.last    = final_step && (op_reg != OP_DET);
        tag_next.det_fin = final_step && (op_reg == OP_DET);
        unique case (op_reg)
            OP_MUL: begin
                tag_next.acc_clr = (k_reg == '0);
                tag_next.emit    = (k_reg == LAST_IDX);
            end
            OP_DET: begin
                tag_next.acc_clr = !s_reg && (i_reg == '0);
                tag_next.emit    = final_step;
            end
            default: begin
                tag_next.acc_clr = 1'b0;
                tag_next.emit    = 1'b1;
            end
        endcase
    end

    // Element stores
    m3au_ram #(
        .WIDTH (EW),
        .DEPTH (CELLS)
    ) u_ram_a (
        .aclk  (aclk),
        .we    (load_hit && !s_matrix_sel),
        .waddr (load_addr),
        .wdata (EW'(s_element_value)),
        .re    (issue),
        .raddr (addr_a),
        .rdata (rd_a)
    );

    m3au_ram #(
        .WIDTH (EW),
        .DEPTH (CELLS)
    ) u_ram_b (
        .aclk  (aclk),
        .we    (load_hit && s_matrix_sel),
        .waddr (load_addr),
        .wdata (EW'(s_element_value)),
        .re    (issue),
        .raddr (addr_b),
        .rdata (rd_b)
    );

    // Stage 1 operands; never-written elements read as zero
    assign ea    = rvld_a_reg ? signed'(rd_a) : '0;
    assign eb    = rvld_b_reg ? signed'(rd_b) : '0;
    assign e_sel = st1_reg.src ? eb : ea;
    assign fac_s = signed'({1'b0, factor_reg});

    assign scale_prod = SCL_W'(e_sel) * SCL_W'(fac_s);
    assign mul_x      = (st1_reg.op == OP_MUL) ? PROD2_W'(eb) : prod_a_reg;
    assign mult_a     = PROD3_W'(mul_x) * PROD3_W'(ea);
    assign mult_b     = PROD3_W'(prod_b_reg) * PROD3_W'(eb);

    assign term_a = ACC_W'(mult_a);
    assign term_b = ACC_W'(mult_b);
    assign base_a = st1_reg.acc_clr ? '0 : acc_a_reg;
    assign base_b = st1_reg.acc_clr ? '0 : acc_b_reg;

    // Accumulate dot products and determinant terms
    always_comb begin
        acc_a_next  = acc_a_reg;
        acc_b_next  = acc_b_reg;
        prod_a_next = prod_a_reg;
        prod_b_next = prod_b_reg;
        unique case (st1_reg.op)
            OP_MUL: begin
                acc_a_next = base_a + term_a;
            end
            OP_DET: begin
                if (st1_reg.kk == '0) begin
                    prod_a_next = PROD2_W'(ea);
                    prod_b_next = PROD2_W'(eb);
                end else begin
                    prod_a_next = PROD2_W'(mult_a);
                    prod_b_next = PROD2_W'(mult_b);
                end
                if (st1_reg.kk == LAST_IDX) begin
                    acc_a_next = st1_reg.src ? (base_a - term_a) : (base_a + term_a);
                    acc_b_next = st1_reg.src ? (base_b - term_b) : (base_b + term_b);
                end
            end
            default: begin
                acc_a_next = acc_a_reg;
            end
        endcase
    end

    // Result value of the transaction in stage 1
    always_comb begin
        unique case (st1_reg.op)
            OP_MUL, OP_DET: rv = acc_a_next;
            OP_ADD:         rv = ACC_W'(ea) + ACC_W'(eb);
            OP_SUB:         rv = ACC_W'(ea) - ACC_W'(eb);
            OP_SCALE:       rv = ACC_W'(scale_prod);
            default:        rv = ACC_W'(e_sel);
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            s_reg       <= 1'b0;
            i_reg       <= '0;
            j_reg       <= '0;
            k_reg       <= '0;
            valid_a_reg <= '0;
            valid_b_reg <= '0;
            st1_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            s_reg     <= s_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            if (load_hit && !s_matrix_sel) begin
                valid_a_reg[load_addr] <= 1'b1;
            end
            if (load_hit && s_matrix_sel) begin
                valid_b_reg[load_addr] <= 1'b1;
            end
            if (advance) begin
                st1_vld_reg <= issue;
            end
            if ((consume && st1_reg.emit) || detb_emit) begin
                out_vld_reg <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Operation latch, stage 1 and datapath registers
    always_ff @(posedge aclk) begin
        if (start) begin
            op_reg     <= in_op;
            factor_reg <= s_scale_factor;
        end
        if (issue) begin
            st1_reg    <= tag_next;
            rvld_a_reg <= valid_a_reg[addr_a];
            rvld_b_reg <= valid_b_reg[addr_b];
        end
        if (consume) begin
            acc_a_reg  <= acc_a_next;
            acc_b_reg  <= acc_b_next;
            prod_a_reg <= prod_a_next;
            prod_b_reg <= prod_b_next;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (consume && st1_reg.emit) begin
            out_value_reg <= sat_res(rv);
            out_kind_reg  <= (st1_reg.op == OP_DET);
            out_src_reg   <= ((st1_reg.op == OP_SCALE) || (st1_reg.op == OP_TRANS)) &&
                             st1_reg.src;
            out_row_reg   <= (st1_reg.op == OP_DET) ? '0 : st1_reg.row;
            out_col_reg   <= (st1_reg.op == OP_DET) ? '0 : st1_reg.col;
            out_last_reg  <= st1_reg.last;
        end else if (detb_emit) begin
            out_value_reg <= sat_res(acc_b_reg);
            out_kind_reg  <= 1'b1;
            out_src_reg   <= 1'b1;
            out_row_reg   <= '0;
            out_col_reg   <= '0;
            out_last_reg  <= 1'b1;
        end
    end

    assign m_valid         = out_vld_reg;
    assign m_result_value  = out_value_reg;
    assign m_result_kind   = out_kind_reg;
    assign m_source_matrix = out_src_reg;
    assign m_out_row       = out_row_reg;
    assign m_out_col       = out_col_reg;
    assign m_last          = out_last_reg;

endmodule

`default_nettype wire

// ===== hdl/m3au_checker.sv =====
`default_nettype none

`include "matrix3x3_arithmetic_unit_macros.svh"

module m3au_checker
    import m3au_pkg::*;
(
    input wire logic                    aclk,
    input wire logic                    aresetn,
    input wire logic                    s_valid,
    input wire logic                    s_ready,
    input wire logic [2:0]              s_op,
    input wire logic                    s_matrix_sel,
    input wire logic [1:0]              s_row_index,
    input wire logic [1:0]              s_col_index,
    input wire logic signed [7:0]       s_element_value,
    input wire logic [3:0]              s_scale_factor,
    input wire logic                    m_valid,
    input wire logic                    m_ready,
    input wire logic signed [RES_W-1:0] m_result_value,
    input wire logic                    m_result_kind,
    input wire logic                    m_source_matrix,
    input wire logic [1:0]              m_out_row,
    input wire logic [1:0]              m_out_col,
    input wire logic                    m_last
);

    // A stalled result transaction holds its payload
    `M3AU_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_result_value) && $stable(m_last))

    // No new operation is taken while a run is still emitting
    `M3AU_ASSERT_IMP(a_busy_mid_run, aclk, aresetn, m_valid && !m_last, !s_ready)

    // Determinants carry no position
    `M3AU_ASSERT_IMP(a_det_pos, aclk, aresetn, m_valid && m_result_kind, (m_out_row == 2'd0) && (m_out_col == 2'd0))

    // The closing determinant is always that of B
    `M3AU_ASSERT_IMP(a_det_last_b, aclk, aresetn, m_valid && m_result_kind && m_last, m_source_matrix)

endmodule

bind matrix3x3_arithmetic_unit m3au_checker u_m3au_checker (.*);

`default_nettype wire
